/* design/clc_pkg.sv */
// Shared types and codes for the config line classifier.
`default_nettype none

package clc_pkg;

    // Line phases
    localparam logic [2:0] PH_LEAD    = 3'd0;
    localparam logic [2:0] PH_KEY     = 3'd1;
    localparam logic [2:0] PH_MID     = 3'd2;
    localparam logic [2:0] PH_VALUE   = 3'd3;
    localparam logic [2:0] PH_TRAIL   = 3'd4;
    localparam logic [2:0] PH_DISCARD = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // Line classes
    localparam logic [2:0] CLS_BLANK   = 3'd0;
    localparam logic [2:0] CLS_COMMENT = 3'd1;
    localparam logic [2:0] CLS_KV      = 3'd2;
    localparam logic [2:0] CLS_KV_CMT  = 3'd3;
    localparam logic [2:0] CLS_INVALID = 3'd4;

    // Characters of interest
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // Depth of the queue between classifier and output stage
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [2:0] cls;
    } clc_result_t;

endpackage

`default_nettype wire

/* design/clc_front.sv */
// Front end: accepts characters, tracks line state and classifies.
`default_nettype none

module clc_front
    import clc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  char_in,
    output logic             push,
    output clc_result_t      push_data
);

    logic [2:0] phase_reg, phase_next;
    logic       equals_seen_reg, equals_seen_next;
    logic [1:0] quote_count_reg, quote_count_next;
    logic       emit;
    logic [2:0] other_phase;
    logic       line_end;

    assign line_end = (char_in == CH_LF) || (char_in == CH_NUL);

    // Classify the current beat against the line state
    always_comb
    begin
        phase_next       = phase_reg;
        equals_seen_next = equals_seen_reg;
        quote_count_next = quote_count_reg;
        emit             = 1'b0;
        push_data.kind   = KIND_DONE;
        push_data.ch     = CH_NUL;
        push_data.cls    = CLS_BLANK;
        other_phase      = phase_reg;

        if (phase_reg > PH_TRAIL)
        begin
            if (line_end)
            begin
                phase_next       = PH_LEAD;
                equals_seen_next = 1'b0;
                quote_count_next = 2'd0;
            end
        end
        else if (char_in == CH_SPACE)
        begin
            if (quote_count_reg == 2'd1 && phase_reg == PH_VALUE)
            begin
                emit           = 1'b1;
                push_data.kind = KIND_VALUE;
                push_data.ch   = char_in;
            end
            else if (phase_reg == PH_KEY || phase_reg == PH_VALUE)
            begin
                phase_next = phase_reg + 3'd1;
            end
        end
        else if (line_end)
        begin
            emit             = 1'b1;
            phase_next       = PH_LEAD;
            equals_seen_next = 1'b0;
            quote_count_next = 2'd0;
            if (phase_reg == PH_LEAD)
                push_data.cls = CLS_BLANK;
            else if (phase_reg == PH_TRAIL
                     || (phase_reg == PH_VALUE && quote_count_reg != 2'd1))
                push_data.cls = equals_seen_reg ? CLS_KV : CLS_INVALID;
            else
                push_data.cls = CLS_INVALID;
        end
        else if (char_in == CH_HASH)
        begin
            emit       = 1'b1;
            phase_next = PH_DISCARD;
            if (phase_reg >= PH_VALUE)
                push_data.cls = equals_seen_reg ? CLS_KV_CMT : CLS_INVALID;
            else if (phase_reg == PH_LEAD)
                push_data.cls = CLS_COMMENT;
            else
                push_data.cls = CLS_INVALID;
        end
        else if (char_in == CH_EQ)
        begin
            if (!equals_seen_reg && phase_reg == PH_VALUE)
            begin
                equals_seen_next = 1'b1;
                phase_next       = PH_TRAIL;
            end
            else if (!equals_seen_reg && phase_reg == PH_MID)
            begin
                equals_seen_next = 1'b1;
            end
            else
            begin
                emit          = 1'b1;
                push_data.cls = CLS_INVALID;
                phase_next    = PH_DISCARD;
            end
        end
        else if (char_in == CH_QUOTE)
        begin
            emit = 1'b1;
            if (phase_reg == PH_MID || phase_reg == PH_VALUE)
            begin
                phase_next     = phase_reg + 3'd1;
                push_data.kind = KIND_VALUE;
                push_data.ch   = char_in;
                if (quote_count_reg != 2'd3)
                    quote_count_next = quote_count_reg + 2'd1;
            end
            else
            begin
                push_data.cls = CLS_INVALID;
                phase_next    = PH_DISCARD;
            end
        end
        else
        begin
            // Enter or extend key or value on an ordinary character; after the value the line is invalid
            if (phase_reg == PH_LEAD)
                other_phase = PH_KEY;
            else if (phase_reg == PH_MID)
                other_phase = PH_VALUE;
            phase_next = other_phase;
            emit       = 1'b1;
            if (other_phase == PH_KEY)
            begin
                push_data.kind = KIND_KEY;
                push_data.ch   = char_in;
            end
            else if (other_phase == PH_VALUE)
            begin
                push_data.kind = KIND_VALUE;
                push_data.ch   = char_in;
            end
            else
            begin
                push_data.cls = CLS_INVALID;
                phase_next    = PH_DISCARD;
            end
        end
    end

    assign push = accept && emit;

    // Advance line state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LEAD;
            equals_seen_reg <= 1'b0;
            quote_count_reg <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            equals_seen_reg <= equals_seen_next;
            quote_count_reg <= quote_count_next;
        end
    end

endmodule

`default_nettype wire

/* design/clc_queue.sv */
// Small result queue between the classifier and the output stage.
`default_nettype none

module clc_queue
    import clc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire clc_result_t push_data,
    input  wire logic        pop,
    output logic             full,
    output logic             nonempty,
    output clc_result_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    clc_result_t      slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign nonempty = (count_reg != '0);
    assign head     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
    end

    // Store pushed beats
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count exceeds depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty)
        else $error("pop from empty queue");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count did not grow on push");

endmodule

`default_nettype wire

/* design/clc_back.sv */
// Back end: output register that presents queued results.
`default_nettype none

module clc_back
    import clc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        nonempty,
    input  wire clc_result_t head,
    output logic             pop,
    input  wire logic        result_stall,
    output logic             result_valid,
    output logic [1:0]       out_kind,
    output logic [7:0]       out_char,
    output logic [2:0]       line_class
);

    logic        valid_reg;
    clc_result_t data_reg;

    // Load the next beat when the output register is empty or being taken
    assign pop = nonempty && (!valid_reg || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (!result_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= head;
    end

    assign result_valid = valid_reg;
    assign out_kind     = data_reg.kind;
    assign out_char     = data_reg.ch;
    assign line_class   = data_reg.cls;

endmodule

`default_nettype wire

/* design/config_line_classifier.sv */
// Top level of the config line classifier.
// One character per cycle while char_stall is low; line state updates on each accept.
// A result goes through the queue slot and output register; result_stall can hold it.
// char_stall rises while the result queue holds QUEUE_DEPTH undelivered results.
// Reset (rst_n low, asynchronous) returns the line to leading whitespace and
// empties the queue and the output register.
`default_nettype none

module config_line_classifier
    import clc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        char_valid,
    output logic             char_stall,
    input  wire logic [7:0]  char_in,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [1:0]       out_kind,
    output logic [7:0]       out_char,
    output logic [2:0]       line_class
);

    logic        accept;
    logic        push;
    logic        pop;
    logic        full;
    logic        nonempty;
    clc_result_t push_data;
    clc_result_t head;

    assign char_stall = full;
    assign accept     = char_valid && !full;

    clc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_in   (char_in),
        .push      (push),
        .push_data (push_data)
    );

    clc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (full),
        .nonempty  (nonempty),
        .head      (head)
    );

    clc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .nonempty     (nonempty),
        .head         (head),
        .pop          (pop),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .out_kind     (out_kind),
        .out_char     (out_char),
        .line_class   (line_class)
    );

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the config line classifier: directed table, random lines, scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import clc_pkg::*;

    localparam int ITEM_GOAL   = 950;
    localparam int HOLD_CYCLES = 120;

    typedef struct packed {
        logic [7:0]  ch;
        logic        typed;
        clc_result_t want;
    } stim_row_t;

    localparam clc_result_t UNTYPED = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        char_valid = 1'b0;
    logic        char_stall;
    logic [7:0]  char_in = 8'h00;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [1:0]  out_kind;
    logic [7:0]  out_char;
    logic [2:0]  line_class;

    // Line state as the classifier should hold it
    logic [2:0]  ln_phase = PH_LEAD;
    logic        ln_eq = 1'b0;
    logic [1:0]  ln_quotes = 2'd0;

    clc_result_t pending_beats[$];
    logic [7:0]  line_buf[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int send_idle_plan[4]  = '{0, 50, 0, 22};
    int recv_stall_plan[4] = '{0, 0, 50, 22};
    logic hold_req = 1'b0;
    logic hold_off = 1'b0;

    int error_count   = 0;
    int chars_sent    = 0;
    int lines_built   = 0;
    int beats_checked = 0;
    int classes_seen[8] = '{default: 0};

    // Directed beats: fixed classes are typed in, the rest come from the line predictor
    stim_row_t directed_rows[26] = '{
        '{CH_LF,    1'b1, '{KIND_DONE, 8'h00, CLS_BLANK}},    // empty line
        '{CH_NUL,   1'b1, '{KIND_DONE, 8'h00, CLS_BLANK}},    // NUL also ends a line
        '{CH_SPACE, 1'b0, UNTYPED},
        '{CH_HASH,  1'b1, '{KIND_DONE, 8'h00, CLS_COMMENT}},  // comment line
        '{8'hFF,    1'b0, UNTYPED},                           // dropped after comment
        '{CH_LF,    1'b0, UNTYPED},                           // silent end of dropped line
        '{CH_EQ,    1'b1, '{KIND_DONE, 8'h00, CLS_INVALID}},  // equals before any key
        '{CH_NUL,   1'b0, UNTYPED},
        '{8'h6B,    1'b0, UNTYPED},
        '{8'h80,    1'b0, UNTYPED},
        '{CH_SPACE, 1'b0, UNTYPED},
        '{CH_EQ,    1'b0, UNTYPED},
        '{CH_QUOTE, 1'b0, UNTYPED},
        '{CH_SPACE, 1'b0, UNTYPED},                           // space inside open quote
        '{8'h01,    1'b0, UNTYPED},
        '{CH_QUOTE, 1'b0, UNTYPED},
        '{CH_LF,    1'b1, '{KIND_DONE, 8'h00, CLS_KV}},
        '{8'h61,    1'b0, UNTYPED},
        '{CH_QUOTE, 1'b1, '{KIND_DONE, 8'h00, CLS_INVALID}},  // quote inside key
        '{CH_LF,    1'b0, UNTYPED},
        '{8'h61,    1'b0, UNTYPED},
        '{CH_SPACE, 1'b0, UNTYPED},
        '{8'h62,    1'b0, UNTYPED},
        '{CH_EQ,    1'b0, UNTYPED},                           // equals ends the value
        '{CH_EQ,    1'b1, '{KIND_DONE, 8'h00, CLS_INVALID}},  // second equals
        '{CH_LF,    1'b0, UNTYPED}
    };

    config_line_classifier DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_in      (char_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_kind     (out_kind),
        .out_char     (out_char),
        .line_class   (line_class)
    );

    always #5 clk = ~clk;

    function automatic clc_result_t done_beat(input logic [2:0] cls);
        return '{KIND_DONE, 8'h00, cls};
    endfunction

    function automatic clc_result_t char_beat(input logic [1:0] kind, input logic [7:0] c);
        return '{kind, c, CLS_BLANK};
    endfunction

    // Advance the line state by one character; return 1 when a beat is due
    function automatic bit classify_char(input logic [7:0] c, output clc_result_t beat);
        logic [2:0] cls;
        beat = '0;
        cls = CLS_INVALID;
        if (ln_phase > PH_TRAIL) begin
            if (c == CH_LF || c == CH_NUL) begin
                ln_phase = PH_LEAD;
                ln_eq = 1'b0;
                ln_quotes = 2'd0;
            end
            return 1'b0;
        end
        if (c == CH_SPACE) begin
            if (ln_quotes == 2'd1 && ln_phase == PH_VALUE) begin
                beat = char_beat(KIND_VALUE, c);
                return 1'b1;
            end
            if (ln_phase == PH_KEY || ln_phase == PH_VALUE)
                ln_phase = ln_phase + 3'd1;
            return 1'b0;
        end
        if (c == CH_LF || c == CH_NUL) begin
            if (ln_phase == PH_LEAD)
                beat = done_beat(CLS_BLANK);
            else if (ln_phase == PH_TRAIL || (ln_phase == PH_VALUE && ln_quotes != 2'd1))
                beat = done_beat(ln_eq ? CLS_KV : CLS_INVALID);
            else
                beat = done_beat(CLS_INVALID);
            ln_phase = PH_LEAD;
            ln_eq = 1'b0;
            ln_quotes = 2'd0;
            return 1'b1;
        end
        if (c == CH_HASH) begin
            if (ln_phase >= PH_VALUE)
                cls = ln_eq ? CLS_KV_CMT : CLS_INVALID;
            else if (ln_phase == PH_LEAD)
                cls = CLS_COMMENT;
        end
        else if (c == CH_EQ) begin
            if (!ln_eq && (ln_phase == PH_VALUE || ln_phase == PH_MID)) begin
                ln_eq = 1'b1;
                if (ln_phase == PH_VALUE)
                    ln_phase = PH_TRAIL;
                return 1'b0;
            end
        end
        else if (c == CH_QUOTE) begin
            if (ln_phase == PH_MID || ln_phase == PH_VALUE) begin
                ln_phase = ln_phase + 3'd1;
                if (ln_quotes != 2'd3)
                    ln_quotes = ln_quotes + 2'd1;
                beat = char_beat(KIND_VALUE, c);
                return 1'b1;
            end
        end
        else begin
            if (ln_phase == PH_LEAD)
                ln_phase = PH_KEY;
            else if (ln_phase == PH_MID)
                ln_phase = PH_VALUE;
            if (ln_phase == PH_KEY) begin
                beat = char_beat(KIND_KEY, c);
                return 1'b1;
            end
            if (ln_phase == PH_VALUE) begin
                beat = char_beat(KIND_VALUE, c);
                return 1'b1;
            end
        end
        // Class decided mid-line: drop the rest of it
        beat = done_beat(cls);
        ln_phase = PH_DISCARD;
        return 1'b1;
    endfunction

    // Pick an ordinary key or value character, sometimes a control or high byte
    function automatic logic [7:0] rand_word_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0:       c = 8'($urandom_range(128, 255));
            1:       c = 8'($urandom_range(1, 31));
            default: c = 8'($urandom_range(33, 126));
        endcase
        if (c == CH_LF || c == CH_HASH || c == CH_EQ || c == CH_QUOTE)
            c = 8'h5F;
        return c;
    endfunction

    // Build one random line: mostly well-formed lines, some broken ones and raw noise
    task automatic build_line();
        int pick;
        line_buf.delete();
        pick = $urandom_range(0, 99);
        repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
        if (pick < 8) begin
            // blank line
        end
        else if (pick < 16) begin
            line_buf.push_back(CH_HASH);
            repeat ($urandom_range(0, 6)) line_buf.push_back(8'($urandom_range(1, 255)));
        end
        else if (pick < 78) begin
            repeat ($urandom_range(1, 6)) line_buf.push_back(rand_word_char());
            if ($urandom_range(0, 9) != 0)
                repeat ($urandom_range(1, 2)) line_buf.push_back(CH_SPACE);
            line_buf.push_back(CH_EQ);
            repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
            if (pick < 56) begin
                repeat ($urandom_range(1, 8)) line_buf.push_back(rand_word_char());
            end
            else begin
                line_buf.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 8))
                    line_buf.push_back(($urandom_range(0, 3) == 0) ? CH_SPACE : rand_word_char());
                if ($urandom_range(0, 7) != 0)
                    line_buf.push_back(CH_QUOTE);
            end
            repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
            if ($urandom_range(0, 3) == 0) begin
                line_buf.push_back(CH_HASH);
                repeat ($urandom_range(0, 4)) line_buf.push_back(rand_word_char());
            end
        end
        else if (pick < 90) begin
            repeat ($urandom_range(1, 10)) begin
                case ($urandom_range(0, 5))
                    0:       line_buf.push_back(CH_SPACE);
                    1:       line_buf.push_back(CH_EQ);
                    2:       line_buf.push_back(CH_QUOTE);
                    3:       line_buf.push_back(CH_HASH);
                    default: line_buf.push_back(rand_word_char());
                endcase
            end
        end
        else begin
            repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
        if (pick < 90)
            line_buf.push_back(($urandom_range(0, 7) == 0) ? CH_NUL : CH_LF);
    endtask

    // Offer one character beat, hold it until taken, then record the expected beat
    task automatic send_char(input logic [7:0] c, input logic typed, input clc_result_t want);
        clc_result_t predicted;
        bit has_beat;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            char_valid <= 1'b0;
            char_in <= 8'($urandom);
            @(negedge clk);
        end
        char_valid <= 1'b1;
        char_in <= c;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        has_beat = classify_char(c, predicted);
        if (typed)
            pending_beats.push_back(want);
        else if (has_beat)
            pending_beats.push_back(predicted);
        chars_sent++;
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Stall the output at random, or solidly during the hold-off
    always @(negedge clk)
        result_stall <= hold_off || ($urandom_range(0, 99) < recv_stall_pct);

    // Hold the output off for a long stretch once requested
    initial begin : output_hold_off
        wait (hold_req);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
    end

    // Compare each delivered beat with the oldest expected one
    always @(posedge clk) begin : result_monitor
        clc_result_t got;
        clc_result_t want;
        if (rst_n && result_valid && !result_stall) begin
            got = {out_kind, out_char, line_class};
            if (pending_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat kind %0d char %02h class %0d",
                                          got.kind, got.ch, got.cls));
            end
            else begin
                want = pending_beats.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch($sformatf("out_kind %0d, want %0d", got.kind, want.kind));
                if (got.ch !== want.ch)
                    report_mismatch($sformatf("out_char %02h, want %02h", got.ch, want.ch));
                if (got.cls !== want.cls)
                    report_mismatch($sformatf("line_class %0d, want %0d", got.cls, want.cls));
                if (want.kind == KIND_DONE)
                    classes_seen[want.cls]++;
                beats_checked++;
            end
        end
    end

    initial begin : run_limit
        #2_000_000;
        $display("Timed out with %0d beats still expected", pending_beats.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_rows[i])
            send_char(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].want);

        // Random lines under each handshake mix; long output hold-off in the first
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_idle_plan[p];
            recv_stall_pct = recv_stall_plan[p];
            if (p == 0)
                hold_req = 1'b1;
            while (chars_sent < (ITEM_GOAL * (p + 1)) / 4) begin
                build_line();
                lines_built++;
                foreach (line_buf[i])
                    send_char(line_buf[i], 1'b0, UNTYPED);
            end
        end
        @(negedge clk);
        char_valid <= 1'b0;

        // Drain, then give trailing beats a chance to show up
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d characters (%0d random lines, four idle/stall mixes, one hold-off);",
                 chars_sent, lines_built);
        $display("checked %0d beats; classes blank %0d comment %0d kv %0d kv+comment %0d invalid %0d",
                 beats_checked, classes_seen[CLS_BLANK], classes_seen[CLS_COMMENT],
                 classes_seen[CLS_KV], classes_seen[CLS_KV_CMT], classes_seen[CLS_INVALID]);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
